### src/bloom_filter_fnv_double_hash_assert.svh
// Assertion helpers shared by the filter modules.
`ifndef BLOOM_FILTER_FNV_DOUBLE_HASH_ASSERT_SVH
`define BLOOM_FILTER_FNV_DOUBLE_HASH_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BFH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bloom filter check failed");

// Next-cycle implication, checked out of reset.
`define BFH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bloom filter check failed");

`endif

### src/bfh_pkg.sv
package bfh_pkg;

  localparam int HASH_W      = 64;
  localparam int NUM_BITS_W  = 17;
  localparam int NUM_HASH_W  = 5;
  localparam int CFG_DATA_W  = 17;
  localparam int CFG_INDEX_W = 1;

  localparam int MAX_BITS_DEF   = 65536;
  localparam int MAX_HASHES_DEF = 16;

  // modulo unit: remainder bits resolved per cycle
  localparam int DIV_STEPS = 4;
  localparam int DIV_ITERS = HASH_W / DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_ITERS);

  localparam logic [HASH_W-1:0] FNV_OFFSET = 64'hcbf29ce484222325;
  localparam logic [HASH_W-1:0] SEED_ONE   = FNV_OFFSET ^ 64'h00000100000001b3;
  localparam logic [HASH_W-1:0] SEED_TWO   = FNV_OFFSET ^ 64'h0000020000000366;

  localparam logic [NUM_BITS_W-1:0] NUM_BITS_RST   = 17'd65521;
  localparam logic [NUM_HASH_W-1:0] NUM_HASHES_RST = 5'd7;

  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_BITS   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_HASHES = 1'b1;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic clr_step;
    logic byte_en;
    logic div_start;
    logic mem_op;
    logic probe_chk;
    logic load_out;
  } bfh_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic k_zero;
    logic div_done;
    logic last_probe;
    logic out_free;
  } bfh_stat_t;

endpackage

### src/bfh_div.sv
`include "bloom_filter_fnv_double_hash_assert.svh"

module bfh_div #(
  parameter int MW = 17
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bfh_pkg::HASH_W-1:0] dividend,
  input  logic [MW-1:0]              modulus,
  output logic                       done,
  output logic [MW-1:0]              rem
);

  logic [bfh_pkg::HASH_W-1:0]    dvd_r, dvd_nxt;
  logic [MW-1:0]                 rem_r, rem_nxt;
  logic [bfh_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r, done_r;
  logic [MW:0]                   trial;

  // restoring remainder, DIV_STEPS dividend bits per cycle
  always_comb begin
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    trial   = '0;
    for (int s = 0; s < bfh_pkg::DIV_STEPS; s++) begin
      trial   = {rem_nxt, dvd_nxt[bfh_pkg::HASH_W-1]};
      dvd_nxt = dvd_nxt << 1;
      if (trial >= {1'b0, modulus}) begin
        trial = trial - {1'b0, modulus};
      end
      rem_nxt = trial[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == bfh_pkg::DIV_CNT_W'(bfh_pkg::DIV_ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

  `BFH_ASSERT_NOW(a_rem_in_range, clk, rst_n, done_r, rem_r < modulus)
  `BFH_ASSERT_NEXT(a_start_busy, clk, rst_n, start, busy_r)

endmodule

### src/bfh_dp.sv
`include "bloom_filter_fnv_double_hash_assert.svh"

module bfh_dp #(
  parameter int MAX_BITS   = bfh_pkg::MAX_BITS_DEF,
  parameter int MAX_HASHES = bfh_pkg::MAX_HASHES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bfh_pkg::bfh_cmd_t               cmd,
  output bfh_pkg::bfh_stat_t              stat,
  input  logic                            cfg_we,
  input  logic [bfh_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bfh_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_cmd,
  input  logic [7:0]                      in_key_byte,
  input  logic                            in_key_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_was_query,
  output logic                            out_maybe_present
);

  localparam int AW = $clog2(MAX_BITS);
  localparam int MW = $clog2(MAX_BITS + 1);
  localparam int KW = $clog2(MAX_HASHES + 1);
  localparam int CW = (MW > bfh_pkg::NUM_BITS_W) ? MW : bfh_pkg::NUM_BITS_W;
  localparam int HW = (KW > bfh_pkg::NUM_HASH_W) ? KW : bfh_pkg::NUM_HASH_W;

  logic [bfh_pkg::NUM_BITS_W-1:0] size_cfg_r;
  logic [bfh_pkg::NUM_HASH_W-1:0] probes_cfg_r;
  logic [bfh_pkg::HASH_W-1:0]     h1_r, h2_r, acc_r, step_r, fold1, fold2;
  logic [KW-1:0]                  probe_cnt_r;
  logic [AW-1:0]                  clr_addr_r;
  logic                           cmd_r, all_set_r, rd_data_r;
  logic                           out_valid_r, out_was_query_r, out_maybe_r;
  logic [CW-1:0]                  nb_ext;
  logic [HW-1:0]                  nh_ext;
  logic [MW-1:0]                  modulus, rem;
  logic [KW-1:0]                  k_sat;
  logic                           div_done;
  logic                           filter_mem_r [MAX_BITS];
  logic                           mem_we, mem_wdata;
  logic [AW-1:0]                  mem_waddr;

  function automatic logic [bfh_pkg::HASH_W-1:0] fold(input logic [bfh_pkg::HASH_W-1:0] h,
                                                      input logic [7:0] b);
    logic [bfh_pkg::HASH_W-1:0] x;
    x = h ^ {56'd0, b};
    // times 2^40 + 0x1b3
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  assign fold1 = fold(h1_r, in_key_byte);
  assign fold2 = fold(h2_r, in_key_byte);

  // clamp registers into the supported ranges
  assign nb_ext = CW'(size_cfg_r);
  assign nh_ext = HW'(probes_cfg_r);
  always_comb begin
    if (nb_ext == '0) begin
      modulus = MW'(1);
    end else if (nb_ext > CW'(MAX_BITS)) begin
      modulus = MW'(MAX_BITS);
    end else begin
      modulus = MW'(nb_ext);
    end
    if (nh_ext > HW'(MAX_HASHES)) begin
      k_sat = KW'(MAX_HASHES);
    end else begin
      k_sat = KW'(nh_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_cfg_r   <= bfh_pkg::NUM_BITS_RST;
      probes_cfg_r <= bfh_pkg::NUM_HASHES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bfh_pkg::CFG_NUM_BITS:   size_cfg_r   <= cfg_data[bfh_pkg::NUM_BITS_W-1:0];
        bfh_pkg::CFG_NUM_HASHES: probes_cfg_r <= cfg_data[bfh_pkg::NUM_HASH_W-1:0];
        default: ;
      endcase
    end
  end

  // hash accumulators, back to seeds after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_r <= bfh_pkg::SEED_ONE;
      h2_r <= bfh_pkg::SEED_TWO;
    end else if (cmd.byte_en) begin
      if (in_key_last) begin
        h1_r <= bfh_pkg::SEED_ONE;
        h2_r <= bfh_pkg::SEED_TWO;
      end else begin
        h1_r <= fold1;
        h2_r <= fold2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_en && in_key_last) begin
      acc_r       <= fold1;
      step_r      <= fold2;
      cmd_r       <= in_cmd;
      probe_cnt_r <= '0;
      all_set_r   <= 1'b1;
    end else if (cmd.probe_chk) begin
      if (cmd_r == bfh_pkg::CMD_QUERY && !rd_data_r) begin
        all_set_r <= 1'b0;
      end
      acc_r       <= acc_r + step_r;
      probe_cnt_r <= probe_cnt_r + 1'b1;
    end
  end

  bfh_div #(.MW(MW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (acc_r),
    .modulus  (modulus),
    .done     (div_done),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign mem_we    = cmd.clr_step || (cmd.mem_op && cmd_r == bfh_pkg::CMD_INSERT);
  assign mem_waddr = cmd.clr_step ? clr_addr_r : rem[AW-1:0];
  assign mem_wdata = !cmd.clr_step;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      filter_mem_r[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_op) begin
      rd_data_r <= filter_mem_r[rem[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_was_query_r <= cmd_r;
      out_maybe_r     <= (cmd_r == bfh_pkg::CMD_QUERY) && all_set_r;
    end
  end

  assign stat.clear_done = (clr_addr_r == AW'(MAX_BITS - 1));
  assign stat.k_zero     = (k_sat == '0);
  assign stat.div_done   = div_done;
  assign stat.last_probe = ({1'b0, probe_cnt_r} + 1'b1) == {1'b0, k_sat};
  assign stat.out_free   = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_was_query     = out_was_query_r;
  assign out_maybe_present = out_maybe_r;

  `BFH_ASSERT_NEXT(a_load_shows, clk, rst_n, cmd.load_out, out_valid_r)

endmodule

### src/bfh_ctrl.sv
`include "bloom_filter_fnv_double_hash_assert.svh"

module bfh_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_key_last,
  output logic               in_stall,
  input  bfh_pkg::bfh_stat_t stat,
  output bfh_pkg::bfh_cmd_t  cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DIVGO  = 3'd2;
  localparam logic [2:0] ST_DIVRUN = 3'd3;
  localparam logic [2:0] ST_MEM    = 3'd4;
  localparam logic [2:0] ST_CHK    = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.byte_en = in_valid;
        if (in_valid && in_key_last) begin
          state_nxt = stat.k_zero ? ST_FINISH : ST_DIVGO;
        end
      end
      ST_DIVGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVRUN;
      end
      ST_DIVRUN: begin
        if (stat.div_done) begin
          state_nxt = ST_MEM;
        end
      end
      ST_MEM: begin
        cmd.mem_op = 1'b1;
        state_nxt  = ST_CHK;
      end
      ST_CHK: begin
        cmd.probe_chk = 1'b1;
        state_nxt     = stat.last_probe ? ST_FINISH : ST_DIVGO;
      end
      ST_FINISH: begin
        // hold until the output register can take the request
        cmd.load_out = stat.out_free;
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  `BFH_ASSERT_NEXT(a_div_to_mem, clk, rst_n, state_r == ST_DIVRUN && stat.div_done,
    state_r == ST_MEM)

endmodule

### src/bloom_filter_fnv_double_hash.sv
// Bloom filter with FNV-1a double hashing. One key byte per request; a byte
// without the last mark is folded into both hashes. The last byte starts k
// probes (k = 0 goes straight to the finish step): each probe runs the 64-bit
// position through the modulo unit, which resolves 4 bits per cycle, then a
// memory step and a check step. A stalled result holds the block in its
// finish step until the output register frees. After reset the bit store is
// cleared one bit per cycle with input stalled; configuration writes are
// taken throughout.
module bloom_filter_fnv_double_hash #(
  parameter int MAX_BITS   = bfh_pkg::MAX_BITS_DEF,
  parameter int MAX_HASHES = bfh_pkg::MAX_HASHES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bfh_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bfh_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_cmd,
  input  logic [7:0]                      in_key_byte,
  input  logic                            in_key_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_was_query,
  output logic                            out_maybe_present
);

  bfh_pkg::bfh_cmd_t  cmd;
  bfh_pkg::bfh_stat_t stat;

  bfh_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_key_last (in_key_last),
    .in_stall    (in_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  bfh_dp #(
    .MAX_BITS   (MAX_BITS),
    .MAX_HASHES (MAX_HASHES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_cmd            (in_cmd),
    .in_key_byte       (in_key_byte),
    .in_key_last       (in_key_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_was_query     (out_was_query),
    .out_maybe_present (out_maybe_present)
  );

endmodule
